### rtl/lqr_state_feedback_step_defines.svh
// Assertion macros for the state-feedback step block.
`ifndef LQR_STATE_FEEDBACK_STEP_DEFINES_SVH
`define LQR_STATE_FEEDBACK_STEP_DEFINES_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define LQR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
// Assert that an expression holds in every cycle out of reset.
`define LQR_ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error(msg);
`endif

### rtl/lqr_pkg.sv
// ----------------------------------------------------------------------------
// lqr_pkg
// Shared types, codes and a saturation helper for the state-feedback block.
// ----------------------------------------------------------------------------
package lqr_pkg;

  // Input function codes.
  localparam logic [2:0] FUNC_LOAD  = 3'd0;
  localparam logic [2:0] FUNC_STATE = 3'd1;
  localparam logic [2:0] FUNC_REF   = 3'd2;
  localparam logic [2:0] FUNC_STEP  = 3'd3;
  localparam logic [2:0] FUNC_CLEAR = 3'd4;

  // Table selector codes.
  localparam logic [3:0] SEL_K     = 4'd0;
  localparam logic [3:0] SEL_C     = 4'd1;
  localparam logic [3:0] SEL_KR    = 4'd2;
  localparam logic [3:0] SEL_KI    = 4'd3;
  localparam logic [3:0] SEL_IMIN  = 4'd4;
  localparam logic [3:0] SEL_IMAX  = 4'd5;
  localparam logic [3:0] SEL_UMIN  = 4'd6;
  localparam logic [3:0] SEL_UMAX  = 4'd7;
  localparam logic [3:0] SEL_DUMAX = 4'd8;

  // Fault codes.
  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_DT   = 2'd1;
  localparam logic [1:0] FAULT_LIM  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_STATES = 2'd0;
  localparam logic [1:0] CFG_INPUTS = 2'd1;
  localparam logic [1:0] CFG_INTEG  = 2'd2;

  // Most results one step can emit.
  localparam int RESULT_LIMIT = 4;

  typedef struct packed {
    logic [2:0]         func;
    logic [3:0]         table_select;
    logic [1:0]         row;
    logic [2:0]         col;
    logic signed [31:0] value;
    logic [31:0]        step_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         channel;
    logic signed [31:0] control_value;
    logic               saturated;
    logic               slew_limited;
    logic [1:0]         fault;
    logic               last;
  } out_item_t;

  // Operand selection for the shared multiplier.
  typedef struct packed {
    logic               go;
    logic signed [32:0] a;
    logic signed [32:0] b;
  } mul_req_t;

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### rtl/lqr_mul.sv
// ----------------------------------------------------------------------------
// lqr_mul
// Shared registered Q16.16 multiplier: floor(a*b / 2^16).
// ----------------------------------------------------------------------------
module lqr_mul (
  input  logic                clk,
  input  lqr_pkg::mul_req_t   req,
  output logic signed [63:0]  prod
);

  logic signed [65:0] full;

  // Operands are 33-bit signed so the unsigned step time fits.
  assign full = req.a * req.b;

  always_ff @(posedge clk) begin
    if (req.go) begin
      prod <= $signed(full[63:0]) >>> 16;
    end
  end

endmodule

### rtl/lqr_state_feedback_step.sv
// ----------------------------------------------------------------------------
// lqr_state_feedback_step
// LQR state feedback with integral action, Q16.16, one shared multiplier.
// ----------------------------------------------------------------------------
// Usage: drive in_item with start high while busy is low to issue a
// transaction. Loads, state, reference and clear transactions leave busy
// low and produce no result. A step runs a sequencer around one registered
// multiplier, each product issued, then accumulated: a limit check of each
// active channel, then per channel K*x and Kr*r, with integral action C*x,
// Ki*dt and (Ki*dt)*e, then dumax*dt and an emit state. Results appear on
// out_item with out_valid high for one cycle each, channel 0 first, the
// final one marked with last in the final busy cycle; the next step may be
// taken one cycle later. A zero step time or inverted limits give a single
// fault result, registered in the fault state and shown in the wait state
// that ends the step. The receiver cannot stall.
// Reset clears all coefficients, states, integrators and previous outputs
// and sets active_states and active_inputs to 1, integral action off.
// Configuration writes are taken at any edge with cfg_we high.
module lqr_state_feedback_step #(
  parameter int MAX_STATES = 8,
  parameter int MAX_INPUTS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lqr_pkg::in_item_t  in_item,
  output logic               out_valid,
  output lqr_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data
);

  `include "lqr_state_feedback_step_defines.svh"

  localparam int SW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int CW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHECK = 11'b00000000010,
    S_DOTK  = 11'b00000000100,
    S_KR    = 11'b00000001000,
    S_DOTC  = 11'b00000010000,
    S_KIDT  = 11'b00000100000,
    S_INTEG = 11'b00001000000,
    S_DUDT  = 11'b00010000000,
    S_EMIT  = 11'b00100000000,
    S_FAULT = 11'b01000000000,
    S_WAIT  = 11'b10000000000
  } state_t;

  // Storage.
  logic signed [31:0] k_r    [MAX_INPUTS][MAX_STATES];
  logic signed [31:0] c_r    [MAX_INPUTS][MAX_STATES];
  logic signed [31:0] coef_r [7][MAX_INPUTS];
  logic signed [31:0] x_r    [MAX_STATES];
  logic signed [31:0] ref_r  [MAX_INPUTS];
  logic signed [31:0] int_r  [MAX_INPUTS];
  logic signed [31:0] prev_r [MAX_INPUTS];
  logic [3:0] act_states_r;
  logic [2:0] act_inputs_r;
  logic       integ_en_r;

  // Sequencer registers.
  state_t             st_r, st_nxt;
  logic               phase_r;
  logic [SW:0]        idx_r;
  logic [CW:0]        ch_r;
  logic [CW:0]        n_m_r;
  logic [SW:0]        n_s_r;
  logic [31:0]        dt_r;
  logic signed [63:0] acc_r;
  logic signed [31:0] raw_r;
  logic signed [31:0] reg_r;
  logic signed [31:0] kdt_r;
  logic [1:0]         fault_r;

  lqr_pkg::mul_req_t  mreq;
  logic signed [63:0] prod;

  lqr_mul u_mul (.clk(clk), .req(mreq), .prod(prod));

  logic [CW-1:0] ch;
  logic [SW-1:0] si;
  assign ch = ch_r[CW-1:0];
  assign si = idx_r[SW-1:0];

  // Effective sizes from the configuration.
  logic [SW:0] eff_n;
  logic [CW:0] eff_m;
  always_comb begin
    eff_n = (act_states_r == 4'd0) ? (SW+1)'(1) :
            ({28'd0, act_states_r} > MAX_STATES) ? (SW+1)'(MAX_STATES) :
            (SW+1)'(act_states_r);
    if (act_inputs_r == 3'd0) eff_m = (CW+1)'(1);
    else if ({29'd0, act_inputs_r} > MAX_INPUTS) eff_m = (CW+1)'(MAX_INPUTS);
    else eff_m = (CW+1)'(act_inputs_r);
    if (eff_m > (CW+1)'(lqr_pkg::RESULT_LIMIT)) eff_m = (CW+1)'(lqr_pkg::RESULT_LIMIT);
  end

  // Per-channel words of the current channel.
  logic signed [31:0] c_kr, c_ki, c_imin, c_imax, c_umin, c_umax, c_du;
  assign c_kr   = coef_r[0][ch];
  assign c_ki   = coef_r[1][ch];
  assign c_imin = coef_r[2][ch];
  assign c_imax = coef_r[3][ch];
  assign c_umin = coef_r[4][ch];
  assign c_umax = coef_r[5][ch];
  assign c_du   = coef_r[6][ch];

  logic last_idx;
  assign last_idx = (idx_r + (SW+1)'(1) == n_s_r);
  logic last_ch;
  assign last_ch = (ch_r + (CW+1)'(1) == n_m_r);

  // Integrator update and output limiting (combinational, from products).
  logic signed [31:0] err, acc_i, u_pre, usat, ufin, dmax;
  logic signed [32:0] delta;
  logic               rl;
  always_comb begin
    err   = lqr_pkg::sat32(64'(ref_r[ch]) - 64'(reg_r));
    acc_i = lqr_pkg::sat32(64'(int_r[ch]) + 64'(lqr_pkg::sat32(prod)));
    if (acc_i < c_imin) acc_i = c_imin;
    if (acc_i > c_imax) acc_i = c_imax;
    u_pre = raw_r;
    usat  = (raw_r < c_umin) ? c_umin : ((raw_r > c_umax) ? c_umax : raw_r);
    dmax  = lqr_pkg::sat32(prod);
    delta = 33'(usat) - 33'(prev_r[ch]);
    ufin  = usat;
    rl    = 1'b0;
    if (c_du > 0) begin
      if (delta > 33'(dmax)) begin
        ufin = 32'(33'(prev_r[ch]) + 33'(dmax));
        rl   = 1'b1;
      end else if (delta < -33'(dmax)) begin
        ufin = 32'(33'(prev_r[ch]) - 33'(dmax));
        rl   = 1'b1;
      end
    end
  end

  // Multiplier operand selection.
  always_comb begin
    mreq.go = (phase_r == 1'b0);
    mreq.a  = 33'(k_r[ch][si]);
    mreq.b  = 33'(x_r[si]);
    unique case (st_r)
      S_KR: begin
        mreq.a = 33'(c_kr);
        mreq.b = 33'(ref_r[ch]);
      end
      S_DOTC: begin
        mreq.a = 33'(c_r[ch][si]);
      end
      S_KIDT: begin
        mreq.a = 33'(c_ki);
        mreq.b = $signed({1'b0, dt_r});
      end
      S_INTEG: begin
        mreq.a = 33'(kdt_r);
        mreq.b = 33'(err);
      end
      S_DUDT: begin
        mreq.a = 33'(c_du);
        mreq.b = $signed({1'b0, dt_r});
      end
      default: begin
        mreq.go = ~phase_r;
      end
    endcase
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (start && in_item.func == lqr_pkg::FUNC_STEP) st_nxt = S_CHECK;
      S_CHECK: begin
        if (dt_r == 32'd0) st_nxt = S_FAULT;
        else if (c_umin >= c_umax || (integ_en_r && c_imin > c_imax)) st_nxt = S_FAULT;
        else if (last_ch) st_nxt = S_DOTK;
      end
      S_DOTK:  if (phase_r && last_idx) st_nxt = S_KR;
      S_KR:    if (phase_r) st_nxt = integ_en_r ? S_DOTC : S_DUDT;
      S_DOTC:  if (phase_r && last_idx) st_nxt = S_KIDT;
      S_KIDT:  if (phase_r) st_nxt = S_INTEG;
      S_INTEG: if (phase_r) st_nxt = S_DUDT;
      S_DUDT:  if (phase_r) st_nxt = S_EMIT;
      S_EMIT:  st_nxt = last_ch ? S_IDLE : S_DOTK;
      S_FAULT: st_nxt = S_WAIT;
      S_WAIT:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  assign busy = (st_r != S_IDLE);

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      phase_r   <= 1'b0;
      idx_r     <= '0;
      ch_r      <= '0;
      out_valid <= 1'b0;
      for (int j = 0; j < MAX_INPUTS; j++) begin
        int_r[j]  <= '0;
        prev_r[j] <= '0;
      end
    end else begin
      st_r      <= st_nxt;
      out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          phase_r <= 1'b0;
          idx_r   <= '0;
          ch_r    <= '0;
          dt_r    <= in_item.step_time;
          n_s_r   <= eff_n;
          n_m_r   <= eff_m;
          fault_r <= (in_item.step_time == 32'd0) ? lqr_pkg::FAULT_DT
                                                   : lqr_pkg::FAULT_LIM;
          acc_r   <= '0;
          if (start && in_item.func == lqr_pkg::FUNC_CLEAR) begin
            for (int j = 0; j < MAX_INPUTS; j++) int_r[j] <= '0;
          end
        end
        S_CHECK: begin
          ch_r <= (st_nxt == S_DOTK) ? '0 : ch_r + (CW+1)'(1);
        end
        S_DOTK, S_DOTC: begin
          phase_r <= ~phase_r;
          if (phase_r) begin
            acc_r <= last_idx ? acc_r + prod : acc_r + prod;
            idx_r <= last_idx ? '0 : idx_r + (SW+1)'(1);
            if (last_idx && st_r == S_DOTC) begin
              reg_r <= lqr_pkg::sat32(acc_r + prod);
            end
          end
        end
        S_KR: begin
          phase_r <= ~phase_r;
          if (phase_r) begin
            raw_r <= lqr_pkg::sat32(prod - acc_r);
            acc_r <= '0;
          end
        end
        S_KIDT: begin
          phase_r <= ~phase_r;
          if (phase_r) kdt_r <= lqr_pkg::sat32(prod);
        end
        S_INTEG: begin
          phase_r <= ~phase_r;
          if (phase_r) begin
            int_r[ch] <= acc_i;
            raw_r     <= lqr_pkg::sat32(64'(raw_r) + 64'(acc_i));
          end
        end
        S_DUDT: begin
          phase_r <= ~phase_r;
          if (phase_r) begin
            prev_r[ch]             <= ufin;
            out_valid              <= 1'b1;
            out_item.channel       <= 2'(ch_r);
            out_item.control_value <= ufin;
            out_item.saturated     <= (usat != u_pre);
            out_item.slew_limited  <= rl;
            out_item.fault         <= lqr_pkg::FAULT_NONE;
            out_item.last          <= last_ch;
          end
        end
        S_EMIT: begin
          acc_r <= '0;
          idx_r <= '0;
          ch_r  <= ch_r + (CW+1)'(1);
        end
        S_FAULT: begin
          out_valid              <= 1'b1;
          out_item.channel       <= 2'd0;
          out_item.control_value <= '0;
          out_item.saturated     <= 1'b0;
          out_item.slew_limited  <= 1'b0;
          out_item.fault         <= fault_r;
          out_item.last          <= 1'b1;
        end
        S_WAIT: begin
          phase_r <= 1'b0;
        end
        default: begin
          phase_r <= 1'b0;
        end
      endcase
    end
  end

  // Coefficient, state and reference loads plus configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_INPUTS; j++) begin
        ref_r[j] <= '0;
        for (int i = 0; i < MAX_STATES; i++) begin
          k_r[j][i] <= '0;
          c_r[j][i] <= '0;
        end
        for (int t = 0; t < 7; t++) coef_r[t][j] <= '0;
      end
      for (int i = 0; i < MAX_STATES; i++) x_r[i] <= '0;
      act_states_r <= 4'd1;
      act_inputs_r <= 3'd1;
      integ_en_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lqr_pkg::CFG_STATES: act_states_r <= cfg_data;
          lqr_pkg::CFG_INPUTS: act_inputs_r <= cfg_data[2:0];
          lqr_pkg::CFG_INTEG:  integ_en_r   <= cfg_data[0];
          default:             integ_en_r   <= integ_en_r;
        endcase
      end
      if (start && !busy) begin
        if (in_item.func == lqr_pkg::FUNC_LOAD && 32'(in_item.row) < MAX_INPUTS) begin
          if (in_item.table_select == lqr_pkg::SEL_K && 32'(in_item.col) < MAX_STATES)
            k_r[CW'(in_item.row)][SW'(in_item.col)] <= in_item.value;
          else if (in_item.table_select == lqr_pkg::SEL_C && 32'(in_item.col) < MAX_STATES)
            c_r[CW'(in_item.row)][SW'(in_item.col)] <= in_item.value;
          else if (in_item.table_select >= lqr_pkg::SEL_KR &&
                   in_item.table_select <= lqr_pkg::SEL_DUMAX)
            coef_r[3'(in_item.table_select - lqr_pkg::SEL_KR)][CW'(in_item.row)]
              <= in_item.value;
        end
        if (in_item.func == lqr_pkg::FUNC_STATE && 32'(in_item.col) < MAX_STATES)
          x_r[SW'(in_item.col)] <= in_item.value;
        if (in_item.func == lqr_pkg::FUNC_REF && 32'(in_item.row) < MAX_INPUTS)
          ref_r[CW'(in_item.row)] <= in_item.value;
      end
    end
  end

  // A result only appears while a step is running.
  `LQR_ASSERT_NEXT(a_res_busy, clk, rst_n, out_valid, busy || out_item.last,
    "result outside of a step")
  // A fault result is always the last one.
  `LQR_ASSERT_ALWAYS(a_fault_last, clk, rst_n,
    !out_valid || out_item.fault == lqr_pkg::FAULT_NONE || out_item.last,
    "fault result not marked last")
  // The block goes back to idle right after the last result.
  `LQR_ASSERT_NEXT(a_last_idle, clk, rst_n, out_valid && out_item.last, !busy,
    "not idle after last result")

endmodule
